// ===== src/cbc_pkg.sv =====
// shared types and helpers for the circle versus box collision block
// no dependencies
`timescale 1ns / 1ps

package cbc_pkg;

  localparam int WORD_W = 32;
  localparam int WIDE_W = 64;
  localparam int NORM_W = 18;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_W,
    S_MUL_H,
    S_DIFF,
    S_EDGE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_R,
    S_DECIDE,
    S_ROOT,
    S_DIV_X,
    S_DIV_Y,
    S_DONE
  } state_t;

  // saturate a wide signed value to 32 signed bits
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[WORD_W-1:0];
  endfunction

  // magnitude of a 32 bit signed value as 32 unsigned bits
  function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
    mag32 = v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

endpackage

// ===== src/cbc_mul.sv =====
// shared 32 by 32 unsigned multiplier with registered product
// depends on cbc_pkg
`timescale 1ns / 1ps

module cbc_mul
  import cbc_pkg::*;
(
  input  logic              clk,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WIDE_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= WIDE_W'(a) * WIDE_W'(b);
  end

endmodule

// ===== src/cbc_sqrt.sv =====
// bit-pair integer square root of a 64 bit value, one step a cycle
// depends on cbc_pkg
`timescale 1ns / 1ps

module cbc_sqrt
  import cbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDE_W-1:0] radicand,
  output logic              done,
  output logic [WORD_W-1:0] root
);

  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] acc;
  logic [WIDE_W-1:0] bitv;
  logic [4:0]        count;
  logic              busy;
  logic [WIDE_W-1:0] trial;

  assign trial = acc + bitv;
  assign root  = acc[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= radicand;
        acc   <= '0;
        bitv  <= WIDE_W'(1) << (WIDE_W - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv  <= bitv >> 2;
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/cbc_div.sv =====
// restoring divider for unit normals: floor(num * 2^frac / den), num <= den
// depends on cbc_pkg
`timescale 1ns / 1ps

module cbc_div
  import cbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_W-1:0]    num,
  input  logic [WORD_W-1:0]    den,
  output logic                 done,
  output logic [FRAC_BITS:0]   quot
);

  localparam int CW = $clog2(FRAC_BITS + 2);

  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] dreg;
  logic [CW-1:0]     count;
  logic              busy;
  logic              take;
  logic [WORD_W:0]   rest;

  assign take = rem >= {1'b0, dreg};
  assign rest = take ? rem - {1'b0, dreg} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= {1'b0, num};
        dreg  <= den;
        quot  <= '0;
      end else if (busy) begin
        quot  <= {quot[FRAC_BITS-1:0], take};
        rem   <= {rest[WORD_W-1:0], 1'b0};
        count <= count + CW'(1);
        if (count == CW'(FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/circle_box_collision.sv =====
// circle versus axis-aligned box collision, signed fixed point
// load: back to ready after the two multiply states, no result
// test: a miss or zero distance settles in the decide state; a hit also runs the 32-step
//   square root and two divides of FRAC_BITS+1 steps
// one item at a time, next transfer the cycle after the result is registered
// reset clears the stored circle and the handshake state
`timescale 1ns / 1ps

module circle_box_collision
  import cbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     cmd,
  input  logic signed [WORD_W-1:0] pos_x,
  input  logic signed [WORD_W-1:0] pos_y,
  input  logic signed [WORD_W-1:0] offset_x,
  input  logic signed [WORD_W-1:0] offset_y,
  input  logic [WORD_W-2:0]        size_w,
  input  logic [WORD_W-2:0]        size_h,
  input  logic signed [WORD_W-1:0] scale_x,
  input  logic signed [WORD_W-1:0] scale_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic signed [WORD_W-1:0] penetration,
  output logic signed [NORM_W-1:0] normal_x,
  output logic signed [NORM_W-1:0] normal_y
);

  state_t state, state_next;

  // stored circle
  logic signed [WORD_W-1:0] circ_x, circ_y, circ_r;

  // captured item
  logic                     is_load;
  logic signed [WORD_W-1:0] box_x, box_y;
  logic [WORD_W-2:0]        w_in, h_in;
  logic signed [WORD_W-1:0] sx_in, sy_in;

  // working values
  logic signed [WIDE_W-1:0] hx, hy, dx, dy;
  logic signed [WORD_W-1:0] ex, ey;
  logic [WIDE_W-1:0]        ex2, d2;
  logic [FRAC_BITS:0]       qx;

  // pending result
  logic                     res_hit;
  logic signed [WORD_W-1:0] res_pen;
  logic signed [NORM_W-1:0] res_nx, res_ny;

  // shared units
  logic [WORD_W-1:0] mul_a, mul_b;
  logic [WIDE_W-1:0] mul_p;
  logic              root_start, root_done;
  logic [WORD_W-1:0] root_val;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_num;
  logic [FRAC_BITS:0] div_q;

  cbc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  cbc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(root_start), .radicand(d2),
    .done(root_done), .root(root_val)
  );

  cbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(root_val),
    .done(div_done), .quot(div_q)
  );

  // truncated product of the shared multiplier, sign from the scale
  logic [WIDE_W-1:0]        prod_mag;
  logic signed [WIDE_W-1:0] prod_s, half_s;
  logic                     prod_neg;

  assign prod_mag = mul_p >> FRAC_BITS;
  assign prod_neg = (state == S_MUL_H) ? sx_in[WORD_W-1] : sy_in[WORD_W-1];
  assign prod_s   = prod_neg ? -$signed(prod_mag) : $signed(prod_mag);
  assign half_s   = prod_neg ? -$signed(prod_mag >> 1) : $signed(prod_mag >> 1);

  // clamp of the centre difference to the box, lower bound first
  logic signed [WIDE_W-1:0] cx, cy;

  always_comb begin
    if (dx < -hx) cx = -hx;
    else if (dx > hx) cx = hx;
    else cx = dx;
    if (dy < -hy) cy = -hy;
    else if (dy > hy) cy = hy;
    else cy = dy;
  end

  logic hit_root;
  assign hit_root = (d2 != '0) && (d2 < mul_p);

  // axis normal for zero distance, one unit masked to the field
  localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) << FRAC_BITS;
  logic [WIDE_W-1:0]        mdx, mdy;
  logic signed [WIDE_W-1:0] ax_nx, ax_ny;

  assign mdx   = dx[WIDE_W-1] ? WIDE_W'(-dx) : WIDE_W'(dx);
  assign mdy   = dy[WIDE_W-1] ? WIDE_W'(-dy) : WIDE_W'(dy);
  assign ax_nx = (dx > 0) ? ONE : -ONE;
  assign ax_ny = (dy > 0) ? ONE : -ONE;

  // signed normal components from the divider
  logic signed [WIDE_W-1:0] qx_s, qy_s;
  assign qx_s = ex[WORD_W-1] ? -$signed(WIDE_W'(qx)) : $signed(WIDE_W'(qx));
  assign qy_s = ey[WORD_W-1] ? -$signed(WIDE_W'(div_q)) : $signed(WIDE_W'(div_q));

  logic out_take;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // sequencer: next state, multiplier operands, unit starts
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    root_start = 1'b0;
    div_start  = 1'b0;
    div_num    = mag32(ex);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_MUL_W;
      end
      S_MUL_W: begin
        mul_a = {1'b0, w_in};
        mul_b = mag32(sx_in);
        state_next = S_MUL_H;
      end
      S_MUL_H: begin
        mul_a = {1'b0, h_in};
        mul_b = mag32(sy_in);
        state_next = is_load ? S_IDLE : S_DIFF;
      end
      S_DIFF: state_next = S_EDGE;
      S_EDGE: state_next = S_SQ_X;
      S_SQ_X: begin
        mul_a = mag32(ex);
        mul_b = mag32(ex);
        state_next = S_SQ_Y;
      end
      S_SQ_Y: begin
        mul_a = mag32(ey);
        mul_b = mag32(ey);
        state_next = S_SQ_R;
      end
      S_SQ_R: begin
        mul_a = mag32(circ_r);
        mul_b = mag32(circ_r);
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (hit_root) begin
          root_start = 1'b1;
          state_next = S_ROOT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          div_start  = 1'b1;
          state_next = S_DIV_X;
        end
      end
      S_DIV_X: begin
        div_num = mag32(ey);
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // stored circle and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      circ_x    <= '0;
      circ_y    <= '0;
      circ_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_IDLE && in_valid && !cmd) begin
        circ_x <= sat32(WIDE_W'(pos_x) + WIDE_W'(offset_x));
        circ_y <= sat32(WIDE_W'(pos_y) + WIDE_W'(offset_y));
      end
      if (state == S_MUL_H && is_load) circ_r <= sat32(prod_s);
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      is_load <= !cmd;
      box_x   <= sat32(WIDE_W'(pos_x) + WIDE_W'(offset_x));
      box_y   <= sat32(WIDE_W'(pos_y) + WIDE_W'(offset_y));
      w_in    <= size_w;
      h_in    <= size_h;
      sx_in   <= scale_x;
      sy_in   <= scale_y;
    end
    unique case (state)
      S_MUL_H: hx <= half_s;
      S_DIFF: begin
        hy <= half_s;
        dx <= WIDE_W'(circ_x) - WIDE_W'(box_x);
        dy <= WIDE_W'(circ_y) - WIDE_W'(box_y);
      end
      S_EDGE: begin
        ex <= sat32(dx - cx);
        ey <= sat32(dy - cy);
      end
      S_SQ_Y: ex2 <= mul_p;
      S_SQ_R: d2 <= ex2 + mul_p;
      S_DECIDE: begin
        // miss and zero distance settle here, a root hit is refined later
        res_hit <= hit_root || (d2 == '0);
        res_pen <= '0;
        res_nx  <= '0;
        res_ny  <= '0;
        if (d2 == '0) begin
          res_pen <= circ_r;
          if (mdx > mdy) res_nx <= ax_nx[NORM_W-1:0];
          else res_ny <= ax_ny[NORM_W-1:0];
        end
      end
      S_ROOT: begin
        if (root_done) begin
          res_pen <= sat32(WIDE_W'(circ_r) - $signed(WIDE_W'(root_val)));
        end
      end
      S_DIV_X: if (div_done) qx <= div_q;
      S_DIV_Y: begin
        if (div_done) begin
          res_nx <= qx_s[NORM_W-1:0];
          res_ny <= qy_s[NORM_W-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          hit         <= res_hit;
          penetration <= res_pen;
          normal_x    <= res_nx;
          normal_y    <= res_ny;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/cbc_checker.sv =====
// checker for the circle versus box collision block: watches both channels,
// predicts each test result and compares it; depends on cbc_pkg
`timescale 1ns / 1ps

module cbc_checker
  import cbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     cmd,
  input  logic signed [WORD_W-1:0] pos_x,
  input  logic signed [WORD_W-1:0] pos_y,
  input  logic signed [WORD_W-1:0] offset_x,
  input  logic signed [WORD_W-1:0] offset_y,
  input  logic [WORD_W-2:0]        size_w,
  input  logic [WORD_W-2:0]        size_h,
  input  logic signed [WORD_W-1:0] scale_x,
  input  logic signed [WORD_W-1:0] scale_y,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     hit,
  input  logic signed [WORD_W-1:0] penetration,
  input  logic signed [NORM_W-1:0] normal_x,
  input  logic signed [NORM_W-1:0] normal_y,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] pen;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
  } contact_t;

  contact_t contact_q[$];
  longint   circ_x, circ_y, circ_r;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint scale_mul(longint a, longint b);
    longint unsigned p;
    p = (absval(a) * absval(b)) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint num, longint unsigned den);
    longint unsigned q;
    q = (absval(num) << FRAC_BITS) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic contact_t box_contact();
    contact_t c;
    longint bx, by, hx, hy, dx, dy, cx, cy, ex, ey, pen, nx, ny, one;
    longint unsigned d2, r2, root_d;
    one = longint'(1) << FRAC_BITS;
    pen = 0; nx = 0; ny = 0;
    c.hit = 1'b0;
    bx = clip32(longint'(pos_x) + longint'(offset_x));
    by = clip32(longint'(pos_y) + longint'(offset_y));
    hx = scale_mul(longint'(size_w), longint'(scale_x)) / 2;
    hy = scale_mul(longint'(size_h), longint'(scale_y)) / 2;
    dx = circ_x - bx;
    dy = circ_y - by;
    // lower bound first, so a negative half extent behaves as ordered
    cx = (dx < -hx) ? -hx : ((dx > hx) ? hx : dx);
    cy = (dy < -hy) ? -hy : ((dy > hy) ? hy : dy);
    ex = clip32(dx - cx);
    ey = clip32(dy - cy);
    d2 = absval(ex) * absval(ex) + absval(ey) * absval(ey);
    r2 = absval(circ_r) * absval(circ_r);
    if (d2 > 0 && d2 < r2) begin
      root_d = root_floor(d2);
      c.hit = 1'b1;
      pen = clip32(circ_r - longint'(root_d));
      nx = unit_comp(ex, root_d);
      ny = unit_comp(ey, root_d);
    end else if (d2 == 0) begin
      c.hit = 1'b1;
      pen = circ_r;
      if (absval(dx) > absval(dy)) nx = (dx > 0) ? one : -one;
      else ny = (dy > 0) ? one : -one;
    end
    c.pen = pen[WORD_W-1:0];
    c.nx = nx[NORM_W-1:0];
    c.ny = ny[NORM_W-1:0];
    return c;
  endfunction

  always @(posedge clk) begin
    contact_t got, want;
    if (rst) begin
      circ_x <= 0;
      circ_y <= 0;
      circ_r <= 0;
      contact_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{hit, penetration, normal_x, normal_y};
        if (contact_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = contact_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("result mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == 1'b0) begin
          circ_x <= clip32(longint'(pos_x) + longint'(offset_x));
          circ_y <= clip32(longint'(pos_y) + longint'(offset_y));
          circ_r <= clip32(scale_mul(longint'(size_w), longint'(scale_x)));
        end else begin
          contact_q.push_back(box_contact());
        end
      end
    end
    pending <= contact_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the collision testbench: clock, reset, stimulus and verdict;
// depends on cbc_pkg, circle_box_collision and cbc_checker
`timescale 1ns / 1ps

module testbench;
  import cbc_pkg::*;

  localparam int N_RANDOM = 1200;
  localparam int QUIET_FROM = 1000;        // no idling on either side after this
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;
  localparam int ONE = 65536;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     cmd = CMD_LOAD;
  logic signed [WORD_W-1:0] pos_x = '0, pos_y = '0, offset_x = '0, offset_y = '0;
  logic [WORD_W-2:0]        size_w = '0, size_h = '0;
  logic signed [WORD_W-1:0] scale_x = '0, scale_y = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     hit;
  logic signed [WORD_W-1:0] penetration;
  logic signed [NORM_W-1:0] normal_x, normal_y;
  int                       fail_count, pending;
  int                       sent = 0;
  bit                       quiet = 1'b0;
  longint                   cycles = 0;

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  circle_box_collision u_top (.*);

  cbc_checker u_chk (.*);

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // present one item and hold it until its transfer
  task automatic put_item(input logic c, input int px, py, ox, oy,
                          input logic [WORD_W-2:0] w, h, input int sx, sy);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c; pos_x <= px; pos_y <= py; offset_x <= ox; offset_y <= oy;
    size_w <= w; size_h <= h; scale_x <= sx; scale_y <= sy;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // small signed value in Q16.16, within +-span units
  function automatic int near_q(int span);
    return $urandom_range(0, 2 * span * ONE) - span * ONE;
  endfunction

  // receiver: random stall bursts, one long hold-off so the block backs up
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (sent >= 150 && sent < 160) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        out_ready <= 1'b1;
        wait (sent >= 160);
      end else begin
        n = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        n = $urandom_range(1, 15);
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int kind;
    logic [WORD_W-2:0] w, h;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: test against the reset circle, then a circle of radius five
    put_item(CMD_TEST, 0, 0, 0, 0, 31'd0, 31'd0, 0, 0);
    put_item(CMD_LOAD, 0, 0, 0, 0, 31'd5 << 16, 31'd0, ONE, 0);
    // zero distance: circle inside the box, centred, then x dominant with both signs, then y dominant
    put_item(CMD_TEST, 0, 0, 0, 0, 31'd4 << 16, 31'd4 << 16, ONE, ONE);
    put_item(CMD_TEST, -ONE, 0, 0, 0, 31'd8 << 16, 31'd8 << 16, ONE, ONE);
    put_item(CMD_TEST, ONE, 0, 0, 0, 31'd8 << 16, 31'd8 << 16, ONE, ONE);
    put_item(CMD_TEST, 0, ONE, 0, 0, 31'd8 << 16, 31'd8 << 16, ONE, ONE);
    // hit at a corner, then a miss
    put_item(CMD_TEST, 3 * ONE, 3 * ONE, 0, 0, 31'd2 << 16, 31'd2 << 16, ONE, ONE);
    put_item(CMD_TEST, 30 * ONE, 0, 0, 0, 31'd2 << 16, 31'd2 << 16, ONE, ONE);
    // negative scale makes the half extents negative
    put_item(CMD_TEST, ONE, 2 * ONE, 0, 0, 31'd4 << 16, 31'd4 << 16, -ONE, -2 * ONE);
    // negative radius
    put_item(CMD_LOAD, 0, 0, ONE, 0, 31'd3 << 16, 31'd0, -ONE, 0);
    put_item(CMD_TEST, 2 * ONE, ONE, 0, 0, 31'd1 << 16, 31'd1 << 16, ONE, ONE);
    // saturating extremes of every field
    put_item(CMD_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h80000000);
    put_item(CMD_TEST, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             31'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h7fffffff);
    put_item(CMD_TEST, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             31'd0, 31'd0, 32'h7fffffff, 32'h80000000);
    put_item(CMD_LOAD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             31'h7fffffff, 31'h0, 32'h80000000, 0);
    put_item(CMD_TEST, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    put_item(CMD_TEST, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             31'd0, 31'd0, 0, 0);

    // random: mostly a circle and boxes in a small arena, some full-range noise
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        w = 31'($urandom); h = 31'($urandom);
        put_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                 w, h, $urandom, $urandom);
      end else if (kind == 1) begin
        w = 31'($urandom_range(0, 12 * ONE));
        h = 31'($urandom);
        put_item(CMD_LOAD, near_q(20), near_q(20), near_q(4), near_q(4),
                 w, h, near_q(2), $urandom);
      end else begin
        w = 31'($urandom_range(0, 12 * ONE));
        h = 31'($urandom_range(0, 12 * ONE));
        put_item(CMD_TEST, near_q(20), near_q(20), near_q(4), near_q(4),
                 w, h, near_q(2), near_q(2));
      end
    end
    in_valid <= 1'b0;

    // drain, then let the block settle
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
